FILE: sv/leib_pkg.sv
// shared constants, types and pointer helpers for the line edit input buffer
`default_nettype none
package leib_pkg;

  localparam int DEPTH = 256;
  localparam int AW    = $clog2(DEPTH);
  localparam int UW    = AW + 1;
  localparam int CW    = 9;
  localparam int MW    = (UW > CW) ? UW : CW;

  localparam logic [CW-1:0] CNT_MAX  = '1;
  localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
  localparam logic [UW-1:0] USED_MAX = UW'(DEPTH);
  localparam logic [UW-1:0] TAB_SLOTS = UW'(4);

  localparam logic [7:0] KEY_BS    = 8'd8;
  localparam logic [7:0] KEY_TAB   = 8'd9;
  localparam logic [7:0] KEY_NL    = 8'd10;
  localparam logic [7:0] KEY_EOT   = 8'd4;
  localparam logic [7:0] KEY_SPACE = 8'd32;

  localparam logic MODE_KEY = 1'b0;
  localparam logic MODE_POP = 1'b1;

  typedef logic [AW-1:0] ptr_t;
  typedef logic [UW-1:0] used_t;
  typedef logic [CW-1:0] cnt_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_FULL,
    ST_NOERASE,
    ST_EMPTY
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_TAB,
    S_POP,
    S_DONE
  } state_t;

  typedef struct packed {
    status_t       status;
    logic          echo_valid;
    logic [7:0]    echo_char;
    logic          read_valid;
    logic [7:0]    read_char;
    logic          read_is_delim;
    logic [CW-1:0] lines;
  } result_t;

  function automatic ptr_t ptr_next(input ptr_t p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  function automatic ptr_t ptr_prev(input ptr_t p);
    return (p == '0) ? PTR_LAST : p - 1'b1;
  endfunction

  function automatic logic is_delim(input logic [7:0] c);
    return (c == KEY_NL) || (c == KEY_EOT);
  endfunction

endpackage
`default_nettype wire

FILE: sv/line_edit_input_buffer_unit.sv
// Keyboard line buffer with editing: key requests append characters (a tab
// stores four spaces, backspace erases within the current line, newline and
// EOT close a line), pop requests return the oldest character. Characters
// live in a single-port 256-entry store; one request is handled at a time.
// A key goes through EXEC and DONE, a pop through EXEC, POP and DONE, a tab
// through EXEC, four TAB writes and DONE; the store writes once per cycle.
// The result sits in an output register, so the next request is taken while
// it waits; at most one result is held in flight behind it.
`default_nettype none
module line_edit_input_buffer_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       in_mode,
  input  wire logic [7:0] in_key_char,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      out_status,
  output logic            out_echo_valid,
  output logic [7:0]      out_echo_char,
  output logic            out_read_valid,
  output logic [7:0]      out_read_char,
  output logic            out_read_is_delim,
  output logic [8:0]      out_lines_ready,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_echo_enable
);

  logic              echo_en_r;
  logic              out_valid_r, out_valid_nxt;
  leib_pkg::result_t out_res_r;
  leib_pkg::result_t res;
  logic              res_valid, res_take;

  leib_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_mode    (in_mode),
    .in_key_char(in_key_char),
    .echo_en    (echo_en_r),
    .res_valid  (res_valid),
    .res_take   (res_take),
    .res        (res)
  );

  assign res_take      = res_valid && (!out_valid_r || out_ready);
  assign out_valid_nxt = res_take || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      echo_en_r   <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        echo_en_r <= cfg_echo_enable;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res_r <= res;
    end
  end

  assign cfg_ready         = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_status        = out_res_r.status;
  assign out_echo_valid    = out_res_r.echo_valid;
  assign out_echo_char     = out_res_r.echo_char;
  assign out_read_valid    = out_res_r.read_valid;
  assign out_read_char     = out_res_r.read_char;
  assign out_read_is_delim = out_res_r.read_is_delim;
  assign out_lines_ready   = out_res_r.lines;

  // one request in flight at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  a_read_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_read_valid |-> out_status == 2'(leib_pkg::ST_OK))
    else $error("read data with bad status");

  a_echo_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_echo_valid |-> !out_read_valid)
    else $error("echo and read in one result");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res_take |=> res_valid && $stable(res))
    else $error("pending result lost");

endmodule
`default_nettype wire

FILE: sv/leib_ram.sv
// generic single-port ram with registered read
`default_nettype none
module leib_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

FILE: sv/leib_ctrl.sv
// request sequencer: pointers, counters and character store accesses
`default_nettype none
module leib_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_mode,
  input  wire logic [7:0]        in_key_char,
  input  wire logic              echo_en,
  output logic                   res_valid,
  input  wire logic              res_take,
  output leib_pkg::result_t      res
);

  leib_pkg::state_t  state_r, state_nxt;
  leib_pkg::ptr_t    rp_r, rp_nxt, wp_r, wp_nxt;
  logic              full_r, full_nxt;
  leib_pkg::cnt_t    lc_r, lc_nxt, er_r, er_nxt;
  logic              mode_r, mode_nxt;
  logic [7:0]        key_r, key_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  leib_pkg::result_t res_r, res_nxt;

  logic              mem_we;
  leib_pkg::ptr_t    mem_addr;
  logic [7:0]        mem_wdata, mem_rdata;

  leib_pkg::used_t   used, free, left;
  logic              acc;
  logic [leib_pkg::CW:0]   er_plus;
  logic [leib_pkg::MW-1:0] er_ext, left_ext;

  leib_ram #(
    .WIDTH(8),
    .DEPTH(leib_pkg::DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= leib_pkg::S_IDLE;
      rp_r    <= '0;
      wp_r    <= '0;
      full_r  <= 1'b0;
      lc_r    <= '0;
      er_r    <= '0;
    end else begin
      state_r <= state_nxt;
      rp_r    <= rp_nxt;
      wp_r    <= wp_nxt;
      full_r  <= full_nxt;
      lc_r    <= lc_nxt;
      er_r    <= er_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r <= mode_nxt;
    key_r  <= key_nxt;
    cnt_r  <= cnt_nxt;
    res_r  <= res_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    rp_nxt    = rp_r;
    wp_nxt    = wp_r;
    full_nxt  = full_r;
    lc_nxt    = lc_r;
    er_nxt    = er_r;
    mode_nxt  = mode_r;
    key_nxt   = key_r;
    cnt_nxt   = cnt_r;
    res_nxt   = res_r;
    mem_we    = 1'b0;
    mem_addr  = wp_r;
    mem_wdata = key_r;
    acc       = 1'b0;

    if (full_r) begin
      used = leib_pkg::USED_MAX;
    end else if (wp_r >= rp_r) begin
      used = leib_pkg::used_t'(wp_r - rp_r);
    end else begin
      used = leib_pkg::USED_MAX - leib_pkg::used_t'(rp_r) + leib_pkg::used_t'(wp_r);
    end
    free     = leib_pkg::USED_MAX - used;
    left     = used - 1'b1;
    er_plus  = {1'b0, er_r} + (leib_pkg::CW+1)'(4);
    er_ext   = leib_pkg::MW'(er_r);
    left_ext = leib_pkg::MW'(left);

    case (state_r)
      leib_pkg::S_IDLE: begin
        if (in_valid) begin
          mode_nxt  = in_mode;
          key_nxt   = in_key_char;
          state_nxt = leib_pkg::S_EXEC;
        end
      end
      leib_pkg::S_EXEC: begin
        res_nxt        = '0;
        res_nxt.status = leib_pkg::ST_OK;
        state_nxt      = leib_pkg::S_DONE;
        if (mode_r == leib_pkg::MODE_KEY) begin
          if (key_r == leib_pkg::KEY_BS) begin
            if (er_r == '0 || used == '0) begin
              res_nxt.status = leib_pkg::ST_NOERASE;
            end else begin
              wp_nxt   = leib_pkg::ptr_prev(wp_r);
              full_nxt = 1'b0;
              er_nxt   = er_r - 1'b1;
              acc      = 1'b1;
            end
          end else if (full_r) begin
            res_nxt.status = leib_pkg::ST_FULL;
          end else if (key_r == leib_pkg::KEY_TAB) begin
            if (free < leib_pkg::TAB_SLOTS) begin
              res_nxt.status = leib_pkg::ST_FULL;
            end else begin
              cnt_nxt   = '0;
              state_nxt = leib_pkg::S_TAB;
              acc       = 1'b1;
            end
          end else begin
            mem_we   = 1'b1;
            wp_nxt   = leib_pkg::ptr_next(wp_r);
            full_nxt = (leib_pkg::ptr_next(wp_r) == rp_r);
            if (leib_pkg::is_delim(key_r)) begin
              if (lc_r != leib_pkg::CNT_MAX) begin
                lc_nxt = lc_r + 1'b1;
              end
              er_nxt = '0;
            end else if (er_r != leib_pkg::CNT_MAX) begin
              er_nxt = er_r + 1'b1;
            end
            acc = 1'b1;
          end
          if (acc && echo_en) begin
            res_nxt.echo_valid = 1'b1;
            res_nxt.echo_char  = key_r;
          end
        end else begin
          if (used == '0) begin
            res_nxt.status = leib_pkg::ST_EMPTY;
          end else begin
            mem_addr  = rp_r;
            state_nxt = leib_pkg::S_POP;
          end
        end
      end
      leib_pkg::S_TAB: begin
        mem_we    = 1'b1;
        mem_wdata = leib_pkg::KEY_SPACE;
        wp_nxt    = leib_pkg::ptr_next(wp_r);
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == 2'd3) begin
          full_nxt  = (leib_pkg::ptr_next(wp_r) == rp_r);
          er_nxt    = er_plus[leib_pkg::CW] ? leib_pkg::CNT_MAX : er_plus[leib_pkg::CW-1:0];
          state_nxt = leib_pkg::S_DONE;
        end
      end
      leib_pkg::S_POP: begin
        rp_nxt             = leib_pkg::ptr_next(rp_r);
        full_nxt           = 1'b0;
        res_nxt.read_valid = 1'b1;
        res_nxt.read_char  = mem_rdata;
        if (leib_pkg::is_delim(mem_rdata)) begin
          res_nxt.read_is_delim = 1'b1;
          if (lc_r != '0) begin
            lc_nxt = lc_r - 1'b1;
          end
        end
        if (er_ext > left_ext) begin
          er_nxt = leib_pkg::CW'(left_ext);
        end
        state_nxt = leib_pkg::S_DONE;
      end
      leib_pkg::S_DONE: begin
        if (res_take) begin
          state_nxt = leib_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = leib_pkg::S_IDLE;
      end
    endcase

    res_nxt.lines = lc_nxt;
  end

  assign in_ready  = (state_r == leib_pkg::S_IDLE);
  assign res_valid = (state_r == leib_pkg::S_DONE);
  assign res       = res_r;

endmodule
`default_nettype wire
